// ===== rtl/dtnp_pkg.sv =====
// Shared types, codes and constants of the decimal text number parser.
package dtnp_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 48;

  // Fraction weight table: 0.1, 0.01, ... until it rounds to zero
  localparam int WEIGHT_DEPTH    = 24;
  localparam int WEIGHT_IDX_BITS = $clog2(WEIGHT_DEPTH);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_POINT = 8'h2e;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED   = 2'd1;
  localparam logic [1:0] MODE_REAL     = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_SIGNED,
    PH_INTDIG,
    PH_AFTERINT,
    PH_POINT,
    PH_FRAC
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POINT_ONLY = 2'd1,
    STATUS_NO_NUMBER  = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] integer_part;
    logic [31:0] fraction;
    logic        negative;
    logic [15:0] consumed;
    status_t     status;
  } result_t;

  // Weight after k fraction digits in Q0.frac_bits, rounded half up each step.
  // Only ever called with constant arguments.
  function automatic logic [63:0] weight_at(int frac_bits, int k);
    logic [64:0] w;
    int          i;
    w = ((65'd1 << (frac_bits - 1)) + 65'd2) / 65'd5;
    for (i = 0; i < k; i++) begin
      w = (w + 65'd5) / 65'd10;
    end
    return w[63:0];
  endfunction

endpackage

// ===== rtl/decimal_text_number_parser_unit.sv =====
// Top level of the decimal text number parser: one character per request.
//
// Input channel (in_valid/in_stall): one ASCII character per request with
// first/last flags; first starts a new string and drops any unfinished one.
// Output channel (out_valid/out_stall): one result per string, given when a
// misfit, the last character or a non-real-mode leading zero ends the parse.
// cfg_we/cfg_wdata write number_mode (0 unsigned, 1 signed, 2/3 real).
//
// Throughput is one character per cycle while in_stall is low; the parse
// state, the integer multiply-by-ten and the digit times weight add all
// work in the same cycle. A result is registered when the character that
// ends the parse is accepted. A two-entry output buffer lets input keep
// flowing while a result waits; in_stall rises only when both entries are
// full, i.e. while the receiver holds out_stall and a second result is
// pending. Synchronous reset returns to idle (characters ignored until
// first), empties the output buffer and sets number_mode to real.
module decimal_text_number_parser_unit #(
  parameter int COUNT_BITS = dtnp_pkg::COUNT_BITS_DEF,
  parameter int FRAC_BITS  = dtnp_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        first,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] integer_part,
  output logic [31:0] fraction,
  output logic        negative,
  output logic [15:0] consumed,
  output logic [1:0]  status
);

  localparam int SUM_W  = FRAC_BITS + 5;
  localparam int FR_SHR = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int FR_SHL = (FRAC_BITS >= 32) ? 0 : 32 - FRAC_BITS;
  localparam logic [dtnp_pkg::WEIGHT_IDX_BITS-1:0] WEIGHT_LAST =
    dtnp_pkg::WEIGHT_IDX_BITS'(dtnp_pkg::WEIGHT_DEPTH - 1);

  // Parse state
  logic [1:0]                             number_mode;
  dtnp_pkg::phase_t                       phase, phase_next;
  logic                                   sign_seen, sign_seen_next;
  logic [31:0]                            int_accum, int_accum_next;
  logic [FRAC_BITS-1:0]                   frac_accum, frac_accum_next;
  logic [dtnp_pkg::WEIGHT_IDX_BITS-1:0]   frac_idx, frac_idx_next;
  logic [COUNT_BITS-1:0]                  char_count, char_count_next;
  logic                                   got_int, got_int_next;

  // Phase after the character, before the return to idle
  dtnp_pkg::phase_t                       parse_ph;

  // Output buffer
  dtnp_pkg::result_t out_reg, skid_reg, res_c;
  logic              skid_valid;

  logic in_accept, out_take, res_fire, done;

  logic [FRAC_BITS-1:0] weight_rom [dtnp_pkg::WEIGHT_DEPTH];

  for (genvar g = 0; g < dtnp_pkg::WEIGHT_DEPTH; g++) begin : g_weight
    assign weight_rom[g] = FRAC_BITS'(dtnp_pkg::weight_at(FRAC_BITS, g));
  end

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Character decode
  logic                 is_digit, real_mode, sign_ok;
  logic [3:0]           digit;
  logic [FRAC_BITS+3:0] frac_add;
  logic [SUM_W-1:0]     frac_sum;

  assign is_digit  = (char_code >= dtnp_pkg::CHAR_ZERO) && (char_code <= dtnp_pkg::CHAR_NINE);
  assign digit     = is_digit ? char_code[3:0] : 4'd0;
  assign real_mode = number_mode >= dtnp_pkg::MODE_REAL;
  assign sign_ok   = number_mode != dtnp_pkg::MODE_UNSIGNED;

  // Next-state logic
  always_comb begin
    dtnp_pkg::phase_t      ph;
    logic                  take;
    logic                  active;
    logic [FRAC_BITS-1:0]  acc_w;
    logic [dtnp_pkg::WEIGHT_IDX_BITS-1:0] idx_w;
    logic [COUNT_BITS-1:0] cnt_w;

    if (first) begin
      ph              = dtnp_pkg::PH_START;
      sign_seen_next  = 1'b0;
      int_accum_next  = 32'd0;
      acc_w           = '0;
      idx_w           = '0;
      cnt_w           = '0;
      got_int_next    = 1'b0;
    end else begin
      ph              = phase;
      sign_seen_next  = sign_seen;
      int_accum_next  = int_accum;
      acc_w           = frac_accum;
      idx_w           = frac_idx;
      cnt_w           = char_count;
      got_int_next    = got_int;
    end

    active          = (ph != dtnp_pkg::PH_IDLE);
    take            = 1'b0;
    done            = 1'b0;
    frac_accum_next = acc_w;
    frac_idx_next   = idx_w;
    char_count_next = cnt_w;
    frac_add        = (FRAC_BITS+4)'(digit) * (FRAC_BITS+4)'(weight_rom[idx_w]);
    frac_sum        = SUM_W'(acc_w) + SUM_W'(frac_add);

    case (ph)
      dtnp_pkg::PH_START, dtnp_pkg::PH_SIGNED: begin
        if (ph == dtnp_pkg::PH_START && sign_ok && char_code == dtnp_pkg::CHAR_MINUS) begin
          sign_seen_next = 1'b1;
          take           = 1'b1;
          ph             = dtnp_pkg::PH_SIGNED;
        end else if (is_digit && digit != 4'd0) begin
          int_accum_next = 32'(digit);
          got_int_next   = 1'b1;
          take           = 1'b1;
          ph             = dtnp_pkg::PH_INTDIG;
        end else if (is_digit) begin
          // leading zero closes the integer part
          got_int_next = 1'b1;
          take         = 1'b1;
          ph           = dtnp_pkg::PH_AFTERINT;
          done         = !real_mode;
        end else if (char_code == dtnp_pkg::CHAR_POINT && real_mode) begin
          take = 1'b1;
          ph   = dtnp_pkg::PH_POINT;
        end
      end
      dtnp_pkg::PH_INTDIG, dtnp_pkg::PH_AFTERINT: begin
        if (ph == dtnp_pkg::PH_INTDIG && is_digit) begin
          int_accum_next = (int_accum_next << 3) + (int_accum_next << 1) + 32'(digit);
          take           = 1'b1;
        end else if (char_code == dtnp_pkg::CHAR_POINT && real_mode) begin
          take = 1'b1;
          ph   = dtnp_pkg::PH_POINT;
        end
      end
      dtnp_pkg::PH_POINT, dtnp_pkg::PH_FRAC: begin
        if (is_digit) begin
          if (frac_sum[SUM_W-1:FRAC_BITS] != '0) begin
            frac_accum_next = '1;
          end else begin
            frac_accum_next = frac_sum[FRAC_BITS-1:0];
          end
          // weight stays zero once the table runs out
          if (idx_w != WEIGHT_LAST) begin
            frac_idx_next = idx_w + 1'b1;
          end
          take = 1'b1;
          ph   = dtnp_pkg::PH_FRAC;
        end
      end
      default: begin
      end
    endcase

    if (take) begin
      if (cnt_w != '1) begin
        char_count_next = cnt_w + 1'b1;
      end
      if (last) begin
        done = 1'b1;
      end
    end else begin
      done = 1'b1;
    end

    parse_ph   = ph;
    done       = done && active;
    phase_next = done ? dtnp_pkg::PH_IDLE : ph;
    if (!active) begin
      phase_next = dtnp_pkg::PH_IDLE;
    end
  end

  // Result formatting, from the state after this character
  always_comb begin
    logic [63:0]          acc64;
    logic [31:0]          count32;
    dtnp_pkg::status_t    st;

    acc64   = 64'(frac_accum_next);
    count32 = 32'(char_count_next);

    st = dtnp_pkg::STATUS_OK;
    if (parse_ph == dtnp_pkg::PH_START || parse_ph == dtnp_pkg::PH_SIGNED) begin
      st = dtnp_pkg::STATUS_NO_NUMBER;
    end else if (parse_ph == dtnp_pkg::PH_POINT && !got_int_next) begin
      st = dtnp_pkg::STATUS_POINT_ONLY;
    end

    res_c.status = st;
    if (st == dtnp_pkg::STATUS_OK) begin
      res_c.integer_part = int_accum_next;
      res_c.fraction     = 32'((acc64 >> FR_SHR) << FR_SHL);
      res_c.negative     = sign_seen_next;
      res_c.consumed     = (count32 > 32'h0000_ffff) ? 16'hffff : count32[15:0];
    end else begin
      res_c.integer_part = 32'd0;
      res_c.fraction     = 32'd0;
      res_c.negative     = 1'b0;
      res_c.consumed     = 16'd0;
    end
  end

  assign res_fire = in_accept && done;

  // Configuration and parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode <= dtnp_pkg::MODE_REAL;
      phase       <= dtnp_pkg::PH_IDLE;
    end else begin
      if (cfg_we) begin
        number_mode <= cfg_wdata;
      end
      if (in_accept) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      sign_seen  <= sign_seen_next;
      int_accum  <= int_accum_next;
      frac_accum <= frac_accum_next;
      frac_idx   <= frac_idx_next;
      char_count <= char_count_next;
      got_int    <= got_int_next;
    end
  end

  // Two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_fire) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else if (!out_take) begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      if (!out_valid || (out_take && !skid_valid)) begin
        out_reg <= res_c;
      end else begin
        skid_reg <= res_c;
      end
    end else if (out_take && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

  assign integer_part = out_reg.integer_part;
  assign fraction     = out_reg.fraction;
  assign negative     = out_reg.negative;
  assign consumed     = out_reg.consumed;
  assign status       = out_reg.status;

endmodule
